// ----- rtl/adpalu_pkg.sv -----
// ----------------------------------------------------------------------------
// adpalu_pkg
// Shared types, opcode and condition codes for the data-processing ALU.
// ----------------------------------------------------------------------------
package adpalu_pkg;

    // Data-processing opcodes, instruction bits 24:21
    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_ADC = 4'h5;
    localparam logic [3:0] OP_SBC = 4'h6;
    localparam logic [3:0] OP_RSC = 4'h7;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_CMN = 4'hB;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;
    localparam logic [3:0] OP_BIC = 4'hE;
    localparam logic [3:0] OP_MVN = 4'hF;

    // Condition codes, instruction bits 31:28
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    // Shift types, instruction bits 6:5
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Flag positions in the NZCV nibble
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] rn_value;
        logic [31:0] rm_value;
        logic [31:0] rs_value;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  flags_nzcv;
        logic        executed;
        logic        write_dest;
        logic [3:0]  dest_index;
        logic [31:0] result_value;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] value;
        logic        carry;
    } shift_res_t;

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] dbl;
        dbl = {v, v} >> r;
        return dbl[31:0];
    endfunction

endpackage

// ----- rtl/adpalu_shifter.sv -----
// ----------------------------------------------------------------------------
// adpalu_shifter
// Operand 2 generation: rotated immediate or barrel-shifted Rm, with carry.
// ----------------------------------------------------------------------------
module adpalu_shifter (
    input  logic [31:0]              instr_word,
    input  logic [31:0]              rm_value,
    input  logic [31:0]              rs_value,
    input  logic                     carry_in,
    output adpalu_pkg::shift_res_t   op2
);

    logic [3:0]  rot_field;
    logic [4:0]  rot_amt;
    logic [31:0] imm_rot;
    logic [1:0]  sh_type;
    logic [7:0]  amt;
    logic [4:0]  amt5;
    logic        amt_big;
    logic        top;
    logic [32:0] lsl_ext;
    logic [32:0] lsr_ext;
    logic [32:0] asr_ext;
    logic [31:0] ror_val;

    assign rot_field = instr_word[11:8];
    assign rot_amt   = {rot_field, 1'b0};
    assign imm_rot   = adpalu_pkg::rotr32({24'd0, instr_word[7:0]}, rot_amt);
    assign sh_type   = instr_word[6:5];
    assign amt       = instr_word[4] ? rs_value[7:0] : {3'd0, instr_word[11:7]};
    assign amt5      = amt[4:0];
    assign amt_big   = (amt[7:5] != 3'd0);
    assign top       = rm_value[31];

    // Extended forms keep the last bit shifted out next to the result
    assign lsl_ext = {1'b0, rm_value} << amt5;
    assign lsr_ext = {rm_value, 1'b0} >> amt5;
    assign asr_ext = $unsigned($signed({rm_value, 1'b0}) >>> amt5);
    assign ror_val = adpalu_pkg::rotr32(rm_value, amt5);

    always_comb
    begin
        op2.value = rm_value;
        op2.carry = carry_in;
        if (instr_word[25])
        begin
            op2.value = imm_rot;
            op2.carry = (rot_field == 4'd0) ? carry_in : imm_rot[31];
        end
        else if (amt == 8'd0)
        begin
            if (!instr_word[4])
            begin
                // Immediate amount of zero encodes LSR/ASR by 32 or RRX; LSL keeps Rm
                case (sh_type)
                    adpalu_pkg::SH_LSL:
                    begin
                        op2.value = rm_value;
                        op2.carry = carry_in;
                    end
                    adpalu_pkg::SH_LSR:
                    begin
                        op2.value = 32'd0;
                        op2.carry = top;
                    end
                    adpalu_pkg::SH_ASR:
                    begin
                        op2.value = {32{top}};
                        op2.carry = top;
                    end
                    default:
                    begin
                        op2.value = {carry_in, rm_value[31:1]};
                        op2.carry = rm_value[0];
                    end
                endcase
            end
        end
        else
        begin
            case (sh_type)
                adpalu_pkg::SH_LSL:
                begin
                    if (amt_big)
                    begin
                        op2.value = 32'd0;
                        op2.carry = (amt == 8'd32) ? rm_value[0] : 1'b0;
                    end
                    else
                    begin
                        op2.value = lsl_ext[31:0];
                        op2.carry = lsl_ext[32];
                    end
                end
                adpalu_pkg::SH_LSR:
                begin
                    if (amt_big)
                    begin
                        op2.value = 32'd0;
                        op2.carry = (amt == 8'd32) ? top : 1'b0;
                    end
                    else
                    begin
                        op2.value = lsr_ext[32:1];
                        op2.carry = lsr_ext[0];
                    end
                end
                adpalu_pkg::SH_ASR:
                begin
                    if (amt_big)
                    begin
                        op2.value = {32{top}};
                        op2.carry = top;
                    end
                    else
                    begin
                        op2.value = asr_ext[32:1];
                        op2.carry = asr_ext[0];
                    end
                end
                default:
                begin
                    // Multiples of 32 leave Rm as is, carry from bit 31
                    op2.value = ror_val;
                    op2.carry = ror_val[31];
                end
            endcase
        end
    end

endmodule

// ----- rtl/adpalu_alu.sv -----
// ----------------------------------------------------------------------------
// adpalu_alu
// Condition check, sixteen-opcode ALU and flag update for one instruction.
// ----------------------------------------------------------------------------
module adpalu_alu (
    input  adpalu_pkg::in_beat_t     beat,
    input  logic [3:0]               flags_in,
    output adpalu_pkg::out_beat_t    res,
    output logic [3:0]               flags_out
);

    logic                   n_f;
    logic                   z_f;
    logic                   c_f;
    logic                   v_f;
    logic                   pass;
    logic [3:0]             opcode;
    adpalu_pkg::shift_res_t op2;
    logic [31:0]            rn;
    logic [31:0]            add_a;
    logic [31:0]            add_b;
    logic                   add_c;
    logic [32:0]            sum;
    logic [31:0]            alu_val;
    logic                   arith;
    logic                   ovf;
    logic [3:0]             nf;

    assign n_f    = flags_in[adpalu_pkg::FLAG_N];
    assign z_f    = flags_in[adpalu_pkg::FLAG_Z];
    assign c_f    = flags_in[adpalu_pkg::FLAG_C];
    assign v_f    = flags_in[adpalu_pkg::FLAG_V];
    assign opcode = beat.instr_word[24:21];
    assign rn     = beat.rn_value;

    always_comb
    begin
        case (beat.instr_word[31:28])
            adpalu_pkg::COND_EQ: pass = z_f;
            adpalu_pkg::COND_NE: pass = !z_f;
            adpalu_pkg::COND_CS: pass = c_f;
            adpalu_pkg::COND_CC: pass = !c_f;
            adpalu_pkg::COND_MI: pass = n_f;
            adpalu_pkg::COND_PL: pass = !n_f;
            adpalu_pkg::COND_VS: pass = v_f;
            adpalu_pkg::COND_VC: pass = !v_f;
            adpalu_pkg::COND_HI: pass = c_f && !z_f;
            adpalu_pkg::COND_LS: pass = !c_f || z_f;
            adpalu_pkg::COND_GE: pass = (n_f == v_f);
            adpalu_pkg::COND_LT: pass = (n_f != v_f);
            adpalu_pkg::COND_GT: pass = !z_f && (n_f == v_f);
            adpalu_pkg::COND_LE: pass = z_f || (n_f != v_f);
            adpalu_pkg::COND_AL: pass = 1'b1;
            default:             pass = 1'b0;
        endcase
    end

    adpalu_shifter u_shifter (
        .instr_word (beat.instr_word),
        .rm_value   (beat.rm_value),
        .rs_value   (beat.rs_value),
        .carry_in   (c_f),
        .op2        (op2)
    );

    // Select adder operands; subtracts invert one side and add the carry
    always_comb
    begin
        add_a = rn;
        add_b = op2.value;
        add_c = 1'b0;
        case (opcode)
            adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP:
            begin
                add_b = ~op2.value;
                add_c = 1'b1;
            end
            adpalu_pkg::OP_RSB:
            begin
                add_a = op2.value;
                add_b = ~rn;
                add_c = 1'b1;
            end
            adpalu_pkg::OP_ADC:
            begin
                add_c = c_f;
            end
            adpalu_pkg::OP_SBC:
            begin
                add_b = ~op2.value;
                add_c = c_f;
            end
            adpalu_pkg::OP_RSC:
            begin
                add_a = op2.value;
                add_b = ~rn;
                add_c = c_f;
            end
            default:
            begin
                add_a = rn;
                add_b = op2.value;
                add_c = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
    assign ovf = (~(add_a[31] ^ add_b[31])) & (add_a[31] ^ sum[31]);

    always_comb
    begin
        arith = 1'b0;
        case (opcode)
            adpalu_pkg::OP_AND, adpalu_pkg::OP_TST: alu_val = rn & op2.value;
            adpalu_pkg::OP_EOR, adpalu_pkg::OP_TEQ: alu_val = rn ^ op2.value;
            adpalu_pkg::OP_ORR:                     alu_val = rn | op2.value;
            adpalu_pkg::OP_MOV:                     alu_val = op2.value;
            adpalu_pkg::OP_BIC:                     alu_val = rn & ~op2.value;
            adpalu_pkg::OP_MVN:                     alu_val = ~op2.value;
            default:
            begin
                alu_val = sum[31:0];
                arith   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        nf                     = 4'd0;
        nf[adpalu_pkg::FLAG_N] = alu_val[31];
        nf[adpalu_pkg::FLAG_Z] = (alu_val == 32'd0);
        nf[adpalu_pkg::FLAG_C] = arith ? sum[32] : op2.carry;
        nf[adpalu_pkg::FLAG_V] = arith ? ovf : v_f;
    end

    assign flags_out = (pass && beat.instr_word[20]) ? nf : flags_in;

    always_comb
    begin
        res.result_value = pass ? alu_val : 32'd0;
        res.dest_index   = beat.instr_word[15:12];
        res.write_dest   = pass && (opcode[3:2] != 2'b10);
        res.executed     = pass;
        res.flags_nzcv   = flags_out;
    end

endmodule

// ----- rtl/arm_data_processing_alu.sv -----
// ----------------------------------------------------------------------------
// arm_data_processing_alu
// Execute stage for data-processing instructions with barrel shifter.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one instruction beat: the instruction word and
//   the values of Rn, Rm and Rs. Master channel m_* returns one result beat
//   per instruction: result, Rd, write enable, executed flag and the NZCV
//   flags after the instruction.
//   Each beat lands in an input register, passes the condition check,
//   shifter and ALU and is captured in the output register, which drives
//   m_tvalid. One beat is taken per cycle for as long as the receiver
//   keeps m_tready high.
//   The flag register updates when a beat moves into the output register,
//   so the next instruction sees the flags of the one before it.
//   When the receiver stalls, the output register holds and the input
//   register still takes one more beat; s_tready then drops until the
//   output drains.
//   Reset empties both stages and clears the flags to zero.
// ----------------------------------------------------------------------------
module arm_data_processing_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: instr_word[31:0], rn_value[63:32], rm_value[95:64],
    //          rs_value[127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: result_value[31:0], dest_index[35:32], write_dest[36],
    //          executed[37], flags_nzcv[41:38], zero[47:42]
    output logic [47:0]  m_tdata
);

    adpalu_pkg::in_beat_t  in_reg;
    adpalu_pkg::out_beat_t out_reg;
    adpalu_pkg::out_beat_t out_next;
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic [3:0]            flags_reg;
    logic [3:0]            flags_next;
    logic                  advance;
    logic                  take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    adpalu_alu u_alu (
        .beat      (in_reg),
        .flags_in  (flags_reg),
        .res       (out_next),
        .flags_out (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= 4'd0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= adpalu_pkg::in_beat_t'({s_tdata[31:0], s_tdata[63:32],
                                              s_tdata[95:64], s_tdata[127:96]});
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule

// ----- tb/arm_data_processing_alu_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_data_processing_alu_tb
// Self-checking bench for the data-processing execute stage.
// A short table of hand-picked instructions comes first: flags out of reset,
// condition skips, every opcode and the shifter corner cases. About 1600
// random instructions follow. Each accepted beat runs through a predictor of
// the condition check, barrel shifter, ALU and NZCV update. Every result beat
// is checked against the oldest prediction. Both sides stall in random bursts,
// and there is one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_tb;

    localparam int          CLK_PERIOD   = 4;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          CALM_ITEMS   = 200;
    localparam int          LONG_HOLD    = 64;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [3:0]  COND_NV      = 4'hF;

    typedef struct {
        logic [31:0] iw;
        logic [31:0] rn;
        logic [31:0] rm;
        logic [31:0] rs;
    } instr_t;

    // Same layout as m_tdata[41:0]
    typedef struct packed {
        logic [3:0]  flags;
        logic        exec;
        logic        wr;
        logic [3:0]  rd;
        logic [31:0] res;
    } alu_out_t;

    typedef struct {
        instr_t   it;
        bit       typed;
        alu_out_t want;
    } stim_row_t;

    typedef struct {
        logic [31:0] value;
        logic        carry;
    } shift_out_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;

    logic [3:0]   arch_flags;
    alu_out_t     pending_results[$];
    stim_row_t    stim_rows[$];
    int           mismatch_count = 0;
    int           results_seen   = 0;
    int           cycle_count    = 0;
    int           stall_pct      = 25;
    bit           calm           = 1'b0;
    bit           hold_done      = 1'b0;

    arm_data_processing_alu DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] r);
        if (r == 5'd0)
            return v;
        return (v >> r) | (v << (6'd32 - r));
    endfunction

    function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
        logic n, z, c, v;
        n = f[adpalu_pkg::FLAG_N];
        z = f[adpalu_pkg::FLAG_Z];
        c = f[adpalu_pkg::FLAG_C];
        v = f[adpalu_pkg::FLAG_V];
        case (cc)
            adpalu_pkg::COND_EQ: return z;
            adpalu_pkg::COND_NE: return !z;
            adpalu_pkg::COND_CS: return c;
            adpalu_pkg::COND_CC: return !c;
            adpalu_pkg::COND_MI: return n;
            adpalu_pkg::COND_PL: return !n;
            adpalu_pkg::COND_VS: return v;
            adpalu_pkg::COND_VC: return !v;
            adpalu_pkg::COND_HI: return c && !z;
            adpalu_pkg::COND_LS: return !c || z;
            adpalu_pkg::COND_GE: return n == v;
            adpalu_pkg::COND_LT: return n != v;
            adpalu_pkg::COND_GT: return !z && (n == v);
            adpalu_pkg::COND_LE: return z || (n != v);
            adpalu_pkg::COND_AL: return 1'b1;
            default:             return 1'b0;
        endcase
    endfunction

    function automatic shift_out_t operand2_of(input instr_t it, input logic cin);
        shift_out_t so;
        logic [4:0]  rot;
        logic [1:0]  kind;
        logic [7:0]  amt;
        logic        top;
        logic [32:0] ext;
        if (it.iw[25])
        begin
            rot = {it.iw[11:8], 1'b0};
            so.value = ror32({24'd0, it.iw[7:0]}, rot);
            so.carry = (rot == 5'd0) ? cin : so.value[31];
            return so;
        end
        kind = it.iw[6:5];
        top  = it.rm[31];
        if (it.iw[4])
        begin
            amt = it.rs[7:0];
            if (amt == 8'd0)
            begin
                so.value = it.rm;
                so.carry = cin;
                return so;
            end
        end
        else
        begin
            amt = {3'd0, it.iw[11:7]};
            // immediate amount of zero encodes LSR/ASR #32 and RRX
            if (amt == 8'd0)
            begin
                case (kind)
                    adpalu_pkg::SH_LSL:
                    begin
                        so.value = it.rm;
                        so.carry = cin;
                    end
                    adpalu_pkg::SH_LSR:
                    begin
                        so.value = 32'd0;
                        so.carry = top;
                    end
                    adpalu_pkg::SH_ASR:
                    begin
                        so.value = {32{top}};
                        so.carry = top;
                    end
                    default:
                    begin
                        so.value = {cin, it.rm[31:1]};
                        so.carry = it.rm[0];
                    end
                endcase
                return so;
            end
        end
        case (kind)
            adpalu_pkg::SH_LSL:
            begin
                if (amt < 8'd32)
                begin
                    ext = {1'b0, it.rm} << amt;
                    so.value = ext[31:0];
                    so.carry = ext[32];
                end
                else
                begin
                    so.value = 32'd0;
                    so.carry = (amt == 8'd32) && it.rm[0];
                end
            end
            adpalu_pkg::SH_LSR:
            begin
                if (amt < 8'd32)
                begin
                    ext = {it.rm, 1'b0} >> amt;
                    so.value = ext[32:1];
                    so.carry = ext[0];
                end
                else
                begin
                    so.value = 32'd0;
                    so.carry = (amt == 8'd32) && top;
                end
            end
            adpalu_pkg::SH_ASR:
            begin
                if (amt < 8'd32)
                begin
                    so.value = $signed(it.rm) >>> amt;
                    so.carry = it.rm[amt - 8'd1];
                end
                else
                begin
                    so.value = {32{top}};
                    so.carry = top;
                end
            end
            default:
            begin
                if (amt[4:0] == 5'd0)
                begin
                    so.value = it.rm;
                    so.carry = top;
                end
                else
                begin
                    so.value = ror32(it.rm, amt[4:0]);
                    so.carry = so.value[31];
                end
            end
        endcase
        return so;
    endfunction

    // Execute one instruction against arch_flags; update them if it passes and sets flags.
    function automatic alu_out_t execute_dp(input instr_t it);
        alu_out_t    o;
        shift_out_t  so;
        logic [3:0]  f;
        logic [3:0]  nf;
        logic [3:0]  op;
        logic [31:0] b, res, x, y;
        logic [32:0] sum;
        logic        cin, cx, arith;
        f     = arch_flags;
        cin   = f[adpalu_pkg::FLAG_C];
        op    = it.iw[24:21];
        o.rd  = it.iw[15:12];
        res   = 32'd0;
        x     = 32'd0;
        y     = 32'd0;
        cx    = 1'b0;
        sum   = 33'd0;
        arith = 1'b1;
        if (!cond_holds(it.iw[31:28], f))
        begin
            o.res   = 32'd0;
            o.wr    = 1'b0;
            o.exec  = 1'b0;
            o.flags = f;
            return o;
        end
        so = operand2_of(it, cin);
        b  = so.value;
        case (op)
            adpalu_pkg::OP_AND, adpalu_pkg::OP_TST:
            begin
                res   = it.rn & b;
                arith = 1'b0;
            end
            adpalu_pkg::OP_EOR, adpalu_pkg::OP_TEQ:
            begin
                res   = it.rn ^ b;
                arith = 1'b0;
            end
            adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP:
            begin
                x  = it.rn;
                y  = ~b;
                cx = 1'b1;
            end
            adpalu_pkg::OP_RSB:
            begin
                x  = b;
                y  = ~it.rn;
                cx = 1'b1;
            end
            adpalu_pkg::OP_ADD, adpalu_pkg::OP_CMN:
            begin
                x = it.rn;
                y = b;
            end
            adpalu_pkg::OP_ADC:
            begin
                x  = it.rn;
                y  = b;
                cx = cin;
            end
            adpalu_pkg::OP_SBC:
            begin
                x  = it.rn;
                y  = ~b;
                cx = cin;
            end
            adpalu_pkg::OP_RSC:
            begin
                x  = b;
                y  = ~it.rn;
                cx = cin;
            end
            adpalu_pkg::OP_ORR:
            begin
                res   = it.rn | b;
                arith = 1'b0;
            end
            adpalu_pkg::OP_MOV:
            begin
                res   = b;
                arith = 1'b0;
            end
            adpalu_pkg::OP_BIC:
            begin
                res   = it.rn & ~b;
                arith = 1'b0;
            end
            default:
            begin
                res   = ~b;
                arith = 1'b0;
            end
        endcase
        if (arith)
        begin
            sum = {1'b0, x} + {1'b0, y} + {32'd0, cx};
            res = sum[31:0];
        end
        if (it.iw[20])
        begin
            nf[adpalu_pkg::FLAG_N] = res[31];
            nf[adpalu_pkg::FLAG_Z] = (res == 32'd0);
            nf[adpalu_pkg::FLAG_C] = arith ? sum[32] : so.carry;
            nf[adpalu_pkg::FLAG_V] = arith ? (~(x[31] ^ y[31]) & (x[31] ^ res[31]))
                                           : f[adpalu_pkg::FLAG_V];
            arch_flags = nf;
        end
        o.res   = res;
        o.wr    = (op != adpalu_pkg::OP_TST) && (op != adpalu_pkg::OP_TEQ) &&
                  (op != adpalu_pkg::OP_CMP) && (op != adpalu_pkg::OP_CMN);
        o.exec  = 1'b1;
        o.flags = arch_flags;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Instruction building
    // ------------------------------------------------------------------------
    function automatic logic [31:0] dp_word(input logic [3:0] cc, input logic imm,
                                            input logic [3:0] op, input logic s,
                                            input logic [3:0] rd, input logic [11:0] op2);
        return {cc, 2'b00, imm, op, s, 4'h1, rd, op2};
    endfunction

    function automatic logic [11:0] imm_op2(input logic [3:0] rot, input logic [7:0] imm8);
        return {rot, imm8};
    endfunction

    // Rm shifted by an immediate amount
    function automatic logic [11:0] shi_op2(input logic [4:0] amt, input logic [1:0] kind);
        return {amt, kind, 1'b0, 4'h2};
    endfunction

    // Rm shifted by Rs[7:0]
    function automatic logic [11:0] shr_op2(input logic [1:0] kind);
        return {4'h3, 1'b0, kind, 1'b1, 4'h2};
    endfunction

    function automatic stim_row_t plain_row(input logic [31:0] iw, input logic [31:0] rn,
                                            input logic [31:0] rm, input logic [31:0] rs);
        stim_row_t r;
        r.it    = '{iw, rn, rm, rs};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [31:0] iw, input logic [31:0] rn,
                                            input logic [31:0] res, input logic [3:0] rd,
                                            input logic wr, input logic ex,
                                            input logic [3:0] flags);
        stim_row_t r;
        r.it    = '{iw, rn, 32'hFFFF_FFFF, 32'd0};
        r.typed = 1'b1;
        r.want  = '{flags, ex, wr, rd, res};
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // Rs with its low byte biased toward the shift-amount corners
    function automatic logic [31:0] pick_rs();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 6))
            0:       w[7:0] = 8'd0;
            1:       w[7:0] = 8'd32;
            2:       w[7:0] = 8'($urandom_range(1, 31));
            3:       w[7:0] = 8'($urandom_range(33, 255));
            4:       w[7:0] = {3'($urandom_range(1, 7)), 5'd0};
            default: ;
        endcase
        return w;
    endfunction

    function automatic instr_t random_instr();
        instr_t      it;
        logic [3:0]  cc;
        logic [11:0] op2;
        cc  = ($urandom_range(0, 9) < 4) ? adpalu_pkg::COND_AL : 4'($urandom_range(0, 15));
        op2 = 12'($urandom());
        if (!op2[4] && $urandom_range(0, 3) == 0)
            op2[11:7] = 5'd0;
        it.iw = dp_word(cc, 1'($urandom_range(0, 2) == 0), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 9) < 7), 4'($urandom()), op2);
        it.iw[27:26] = 2'($urandom());
        it.iw[19:16] = 4'($urandom());
        it.rn = pick_word();
        it.rm = pick_word();
        it.rs = pick_rs();
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_instr(input instr_t it, input bit typed, input alu_out_t want);
        alu_out_t pred;
        if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.rs, it.rm, it.rn, it.iw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = execute_dp(it);
        pending_results.push_back(typed ? want : pred);
    endtask

    initial
    begin : stimulus
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        arch_flags = 4'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stim_rows.push_back(typed_row(
            dp_word(adpalu_pkg::COND_AL, 1'b1, adpalu_pkg::OP_MOV, 1'b1, 4'd0,
                    imm_op2(4'd0, 8'h00)),
            32'd0, 32'd0, 4'd0, 1'b1, 1'b1, 4'b0100));
        stim_rows.push_back(typed_row(
            dp_word(adpalu_pkg::COND_EQ, 1'b1, adpalu_pkg::OP_ADD, 1'b1, 4'd1,
                    imm_op2(4'd0, 8'h01)),
            32'hFFFF_FFFF, 32'd0, 4'd1, 1'b1, 1'b1, 4'b0110));
        stim_rows.push_back(typed_row(
            dp_word(COND_NV, 1'b1, adpalu_pkg::OP_MOV, 1'b1, 4'd5,
                    imm_op2(4'd0, 8'h55)),
            32'd0, 32'd0, 4'd5, 1'b0, 1'b0, 4'b0110));
        stim_rows.push_back(typed_row(
            dp_word(adpalu_pkg::COND_AL, 1'b1, adpalu_pkg::OP_SUB, 1'b1, 4'd2,
                    imm_op2(4'd0, 8'h01)),
            32'h8000_0000, 32'h7FFF_FFFF, 4'd2, 1'b1, 1'b1, 4'b0011));
        stim_rows.push_back(typed_row(
            dp_word(adpalu_pkg::COND_VS, 1'b0, adpalu_pkg::OP_AND, 1'b1, 4'd3,
                    shi_op2(5'd0, adpalu_pkg::SH_LSL)),
            32'h8000_0000, 32'h8000_0000, 4'd3, 1'b1, 1'b1, 4'b1011));
        stim_rows.push_back(typed_row(
            dp_word(adpalu_pkg::COND_EQ, 1'b0, adpalu_pkg::OP_MOV, 1'b1, 4'd4,
                    shi_op2(5'd3, adpalu_pkg::SH_LSL)),
            32'd0, 32'd0, 4'd4, 1'b0, 1'b0, 4'b1011));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_EOR, 1'b1, 4'd6,
                    shi_op2(5'd0, adpalu_pkg::SH_LSR)),
            32'hA5A5_A5A5, 32'h8000_0001, 32'd0));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_RSB, 1'b1, 4'd7,
                    shi_op2(5'd0, adpalu_pkg::SH_ASR)),
            32'd1, 32'h8000_0000, 32'd0));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_ADC, 1'b1, 4'd8,
                    shi_op2(5'd0, adpalu_pkg::SH_ROR)),
            32'h7FFF_FFFF, 32'h0000_0003, 32'd0));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_SBC, 1'b1, 4'd9,
                    shr_op2(adpalu_pkg::SH_LSL)),
            32'h1234_5678, 32'hDEAD_BEEF, 32'hFFFF_FF00));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_RSC, 1'b1, 4'd10,
                    shr_op2(adpalu_pkg::SH_LSL)),
            32'd0, 32'd1, 32'd32));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_TST, 1'b1, 4'd11,
                    shr_op2(adpalu_pkg::SH_LSL)),
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd33));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_TEQ, 1'b1, 4'd12,
                    shr_op2(adpalu_pkg::SH_LSR)),
            32'h8000_0000, 32'h8000_0000, 32'd32));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_CMP, 1'b1, 4'd13,
                    shr_op2(adpalu_pkg::SH_LSR)),
            32'd0, 32'hFFFF_FFFF, 32'd200));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_CMN, 1'b1, 4'd14,
                    shr_op2(adpalu_pkg::SH_ASR)),
            32'h7FFF_FFFF, 32'h8000_0000, 32'd32));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_ORR, 1'b1, 4'd0,
                    shr_op2(adpalu_pkg::SH_ASR)),
            32'd0, 32'h7FFF_FFFF, 32'd255));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_MOV, 1'b1, 4'd1,
                    shr_op2(adpalu_pkg::SH_ROR)),
            32'd0, 32'h8000_0001, 32'd64));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_BIC, 1'b1, 4'd2,
                    shr_op2(adpalu_pkg::SH_ROR)),
            32'hFFFF_FFFF, 32'h0000_000F, 32'd37));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b1, adpalu_pkg::OP_MVN, 1'b1, 4'd3,
                    imm_op2(4'd15, 8'hFF)),
            32'd0, 32'd0, 32'd0));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b1, adpalu_pkg::OP_MOV, 1'b1, 4'd15,
                    imm_op2(4'd4, 8'h80)),
            32'd0, 32'd0, 32'd0));
        // bits 27:26 and bit 7 of a register shift carry no meaning
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_ADD, 1'b1, 4'd4,
                    shr_op2(adpalu_pkg::SH_LSL)) | 32'h0C00_0080,
            32'd1, 32'd1, 32'd4));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b0, adpalu_pkg::OP_ADD, 1'b1, 4'd5,
                    shi_op2(5'd31, adpalu_pkg::SH_LSL)),
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_AL, 1'b1, adpalu_pkg::OP_SUB, 1'b0, 4'd6,
                    imm_op2(4'd0, 8'h00)),
            32'd0, 32'd0, 32'd0));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_GT, 1'b0, adpalu_pkg::OP_ADC, 1'b0, 4'd7,
                    shr_op2(adpalu_pkg::SH_LSR)),
            32'h8000_0000, 32'hFFFF_FFFF, 32'd31));
        stim_rows.push_back(plain_row(
            dp_word(adpalu_pkg::COND_LE, 1'b0, adpalu_pkg::OP_SBC, 1'b1, 4'd8,
                    shi_op2(5'd1, adpalu_pkg::SH_ASR)),
            32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'd0));

        foreach (stim_rows[k])
            send_instr(stim_rows[k].it, stim_rows[k].typed, stim_rows[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    2:       stall_pct = 35;
                    default: stall_pct = 60;
                endcase
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_instr(random_instr(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("arm_data_processing_alu: match");
        else
            $display("arm_data_processing_alu: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold to back up the input
    // ------------------------------------------------------------------------
    initial
    begin : sink
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        alu_out_t got;
        alu_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[41:0];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with none pending: %h", $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.res !== want.res || got.rd !== want.rd || got.wr !== want.wr ||
                    got.exec !== want.exec || got.flags !== want.flags ||
                    m_tdata[47:42] !== 6'd0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("%0t: beat %0d: want res=%h rd=%0d wr=%b ex=%b nzcv=%b, ",
                               $realtime, results_seen, want.res, want.rd, want.wr,
                               want.exec, want.flags);
                        $display("got res=%h rd=%0d wr=%b ex=%b nzcv=%b pad=%b",
                                 got.res, got.rd, got.wr, got.exec, got.flags,
                                 m_tdata[47:42]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("arm_data_processing_alu: mismatch");
            $finish;
        end
    end

endmodule
